### sv/jfds_pkg.sv
// ----------------------------------------------------------------------------
// jfds_pkg
// Shared types, codes and the marker scan step of the frame dimension scanner.
// ----------------------------------------------------------------------------
package jfds_pkg;

  localparam int PosBits = 24;
  localparam int NepBits = PosBits + 1;
  localparam int CfgBits = 24;
  localparam int CfgIdxBits = 2;
  localparam int OutDataBits = 64;

  localparam logic [CfgIdxBits-1:0] CfgScreenWidth  = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgScreenHeight = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgMaxFrame     = 2'd2;

  localparam logic [11:0] ScreenWidthReset  = 12'd320;
  localparam logic [11:0] ScreenHeightReset = 12'd240;
  localparam logic [23:0] MaxFrameReset     = 24'd262144;

  localparam logic [7:0] MarkerPrefix = 8'hFF;
  localparam logic [7:0] MarkerSof0   = 8'hC0;
  localparam logic [7:0] MarkerSof1   = 8'hC1;
  localparam logic [7:0] MarkerSof2   = 8'hC2;
  localparam logic [7:0] MarkerSoi    = 8'hD8;
  localparam logic [7:0] MarkerEoi    = 8'hD9;
  localparam logic [7:0] MarkerTem    = 8'h01;
  localparam logic [7:0] MarkerRst0   = 8'hD0;
  localparam logic [7:0] MarkerRst7   = 8'hD7;

  typedef logic [PosBits-1:0] pos_t;
  typedef logic [NepBits-1:0] nep_t;

  typedef enum logic [5:0] {
    MODE_SEEK = 6'b000001,
    MODE_MARK = 6'b000010,
    MODE_LENH = 6'b000100,
    MODE_LENL = 6'b001000,
    MODE_SOF  = 6'b010000,
    MODE_DONE = 6'b100000
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_SIZE = 2'd1,
    STATUS_NO_DIMS = 2'd2,
    STATUS_TOO_BIG = 2'd3
  } status_e;

  typedef struct packed {
    mode_e      mode;
    nep_t       nep;
    pos_t       mark_pos;
    logic       sof_seen;
    pos_t       sof_pos;
  } scan_t;

  typedef struct packed {
    pos_t        count;
    logic        overflow;
    logic        sof_seen;
    pos_t        sof_pos;
    logic [15:0] width;
    logic [15:0] height;
  } summary_t;

  localparam scan_t ScanReset = '{
    mode:     MODE_SEEK,
    nep:      nep_t'(2),
    mark_pos: '0,
    sof_seen: 1'b0,
    sof_pos:  '0
  };

  function automatic scan_t scan_step(scan_t st, nep_t q, logic [7:0] b);
    scan_t r;
    r = st;
    case (st.mode)
      MODE_SEEK: begin
        if (q == st.nep) begin
          if (b != MarkerPrefix) begin
            r.nep = q + nep_t'(1);
          end else begin
            r.mark_pos = q[PosBits-1:0];
            r.mode     = MODE_MARK;
          end
        end
      end
      MODE_MARK: begin
        if (b == MarkerSof0 || b == MarkerSof1 || b == MarkerSof2) begin
          r.sof_seen = 1'b1;
          r.sof_pos  = st.mark_pos;
          r.mode     = MODE_SOF;
        end else if (b == MarkerSoi || b == MarkerEoi || b == MarkerTem ||
                     (b >= MarkerRst0 && b <= MarkerRst7)) begin
          r.nep  = {1'b0, st.mark_pos} + nep_t'(2);
          r.mode = MODE_SEEK;
        end else begin
          r.mode = MODE_LENH;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

endpackage

### sv/jfds_scanner.sv
// ----------------------------------------------------------------------------
// jfds_scanner
// Per-byte marker scan state; captures a frame summary on the last byte.
// ----------------------------------------------------------------------------
module jfds_scanner (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_accept_i,
  input  logic [7:0]          frame_byte_i,
  input  logic                last_byte_i,
  input  logic                sum_ready_i,
  output logic                sum_valid_o,
  output jfds_pkg::summary_t  sum_o
);

  jfds_pkg::pos_t     pos_q, pos_d;
  logic               ovf_q, ovf_d;
  jfds_pkg::scan_t    st_q, st_d;
  logic [7:0]         len_hi_q, len_hi_d;
  logic [7:0]         lb_q, lb_d;
  logic [15:0]        fh_q, fh_d;
  logic [15:0]        fw_q, fw_d;
  logic               sum_valid_q, sum_valid_d;
  jfds_pkg::summary_t sum_q, sum_d;

  jfds_pkg::nep_t     q;
  logic [15:0]        seg_len;
  jfds_pkg::pos_t     sof_dist;
  jfds_pkg::scan_t    st_len;

  assign q        = {1'b0, pos_q};
  assign seg_len  = {len_hi_q, frame_byte_i};
  assign sof_dist = pos_q - st_q.sof_pos;

  always_comb begin
    st_len      = st_q;
    st_len.nep  = {1'b0, st_q.mark_pos} + jfds_pkg::nep_t'(2) +
                  jfds_pkg::nep_t'(seg_len);
    st_len.mode = jfds_pkg::MODE_SEEK;
    if (seg_len == 16'd0) begin
      st_len = jfds_pkg::scan_step(
                 jfds_pkg::scan_step(st_len, q - jfds_pkg::nep_t'(1), lb_q),
                 q, frame_byte_i);
    end else if (seg_len == 16'd1) begin
      st_len = jfds_pkg::scan_step(st_len, q, frame_byte_i);
    end
  end

  always_comb begin
    pos_d       = pos_q;
    ovf_d       = ovf_q;
    st_d        = st_q;
    len_hi_d    = len_hi_q;
    lb_d        = lb_q;
    fh_d        = fh_q;
    fw_d        = fw_q;
    sum_d       = sum_q;
    sum_valid_d = sum_valid_q && !sum_ready_i;
    if (in_accept_i) begin
      if (!ovf_q) begin
        if (pos_q == {jfds_pkg::PosBits{1'b1}}) begin
          ovf_d = 1'b1;
        end else begin
          lb_d  = frame_byte_i;
          pos_d = pos_q + jfds_pkg::pos_t'(1);
          case (st_q.mode)
            jfds_pkg::MODE_SEEK, jfds_pkg::MODE_MARK: begin
              st_d = jfds_pkg::scan_step(st_q, q, frame_byte_i);
            end
            jfds_pkg::MODE_LENH: begin
              len_hi_d  = frame_byte_i;
              st_d.mode = jfds_pkg::MODE_LENL;
            end
            jfds_pkg::MODE_LENL: begin
              st_d = st_len;
            end
            jfds_pkg::MODE_SOF: begin
              if (sof_dist == jfds_pkg::pos_t'(5)) begin
                fh_d = {frame_byte_i, 8'h00};
              end else if (sof_dist == jfds_pkg::pos_t'(6)) begin
                fh_d = {fh_q[15:8], frame_byte_i};
              end else if (sof_dist == jfds_pkg::pos_t'(7)) begin
                fw_d = {frame_byte_i, 8'h00};
              end else if (sof_dist == jfds_pkg::pos_t'(8)) begin
                fw_d      = {fw_q[15:8], frame_byte_i};
                st_d.mode = jfds_pkg::MODE_DONE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      if (last_byte_i) begin
        sum_valid_d    = 1'b1;
        sum_d.count    = pos_d;
        sum_d.overflow = ovf_d;
        sum_d.sof_seen = st_d.sof_seen;
        sum_d.sof_pos  = st_d.sof_pos;
        sum_d.width    = fw_d;
        sum_d.height   = fh_d;
        pos_d          = '0;
        ovf_d          = 1'b0;
        st_d           = jfds_pkg::ScanReset;
        len_hi_d       = '0;
        lb_d           = '0;
        fh_d           = '0;
        fw_d           = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      ovf_q       <= 1'b0;
      st_q        <= jfds_pkg::ScanReset;
      len_hi_q    <= '0;
      lb_q        <= '0;
      fh_q        <= '0;
      fw_q        <= '0;
      sum_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      ovf_q       <= ovf_d;
      st_q        <= st_d;
      len_hi_q    <= len_hi_d;
      lb_q        <= lb_d;
      fh_q        <= fh_d;
      fw_q        <= fw_d;
      sum_valid_q <= sum_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  assign sum_valid_o = sum_valid_q;
  assign sum_o       = sum_q;

endmodule

### sv/jfds_classify.sv
// ----------------------------------------------------------------------------
// jfds_classify
// Configuration registers and the frame status and centering result stage.
// ----------------------------------------------------------------------------
module jfds_classify (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [jfds_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [jfds_pkg::CfgBits-1:0]        cfg_data_i,
  input  logic                                sum_valid_i,
  input  jfds_pkg::summary_t                  sum_i,
  output logic                                sum_ready_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [jfds_pkg::OutDataBits-1:0]    out_data_o
);

  logic [11:0] sw_q;
  logic [11:0] sh_q;
  logic [23:0] max_q;
  logic        out_valid_q, out_valid_d;
  logic [jfds_pkg::OutDataBits-1:0] out_data_q, out_data_d;

  logic              take;
  logic              bad_size;
  logic              no_dims;
  logic              too_big;
  jfds_pkg::status_e status;
  logic [15:0]       w;
  logic [15:0]       h;
  logic [11:0]       x_diff;
  logic [11:0]       y_diff;
  logic [10:0]       xo;
  logic [10:0]       yo;
  logic              fill;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q  <= jfds_pkg::ScreenWidthReset;
      sh_q  <= jfds_pkg::ScreenHeightReset;
      max_q <= jfds_pkg::MaxFrameReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        jfds_pkg::CfgScreenWidth:  sw_q  <= cfg_data_i[11:0];
        jfds_pkg::CfgScreenHeight: sh_q  <= cfg_data_i[11:0];
        jfds_pkg::CfgMaxFrame:     max_q <= cfg_data_i[23:0];
        default: begin
        end
      endcase
    end
  end

  assign sum_ready_o = !out_valid_q || out_ready_i;
  assign take        = sum_valid_i && sum_ready_o;

  assign bad_size = sum_i.overflow || (sum_i.count < jfds_pkg::pos_t'(2)) ||
                    ({8'h00, max_q} < 32'(sum_i.count));
  assign no_dims  = !sum_i.sof_seen ||
                    ({1'b0, sum_i.sof_pos} + jfds_pkg::nep_t'(9) >=
                     {1'b0, sum_i.count}) ||
                    (sum_i.width == 16'd0) || (sum_i.height == 16'd0);
  assign too_big  = (sum_i.width > {4'h0, sw_q}) || (sum_i.height > {4'h0, sh_q});
  assign x_diff   = sw_q - sum_i.width[11:0];
  assign y_diff   = sh_q - sum_i.height[11:0];

  always_comb begin
    status = jfds_pkg::STATUS_OK;
    w      = '0;
    h      = '0;
    xo     = '0;
    yo     = '0;
    fill   = 1'b0;
    if (bad_size) begin
      status = jfds_pkg::STATUS_BAD_SIZE;
    end else if (no_dims) begin
      status = jfds_pkg::STATUS_NO_DIMS;
    end else begin
      w = sum_i.width;
      h = sum_i.height;
      if (too_big) begin
        status = jfds_pkg::STATUS_TOO_BIG;
      end else begin
        xo   = x_diff[11:1];
        yo   = y_diff[11:1];
        fill = (sum_i.width[11:0] != sw_q) || (sum_i.height[11:0] != sh_q);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    if (take) begin
      out_valid_d = 1'b1;
      out_data_d  = {7'b0, fill, yo, xo, h, w, status};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### sv/jpeg_frame_dimension_scanner_top.sv
// ----------------------------------------------------------------------------
// jpeg_frame_dimension_scanner_top
// Finds the frame dimensions in a JPEG marker stream and reports a status.
// ----------------------------------------------------------------------------
// The slave stream carries one frame byte per request in s_axis_tdata, with
// s_axis_tlast on the final byte of the frame. While s_axis_tready is high,
// every offered byte is taken, so a frame streams in at one byte per clock.
// For each final byte, one result request appears on the master stream: the
// status, the image width and height, the centering offsets and the fill
// flag. The edge that accepts the final byte captures the frame summary in
// the summary register; the output register takes the result when free.
// The summary register and the output register form a two-entry path, so
// the input keeps taking bytes while a result waits on m_axis_tready; only
// when both are full does s_axis_tready drop.
// Configuration writes go through cfg_we_i, cfg_idx_i and cfg_data_i and
// take effect at once; they are meant for idle periods between frames.
// Reset clears the scan state, empties both result registers and loads the
// default screen size of 320 by 240 and a 262144-byte frame limit.
// ----------------------------------------------------------------------------
module jpeg_frame_dimension_scanner_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // frame_byte
  input  logic                                s_axis_tlast,  // last_byte
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // status[1:0], image_width[17:2], image_height[33:18], x_offset[44:34],
  // y_offset[55:45], fill_needed[56], zero fill above.
  output logic [jfds_pkg::OutDataBits-1:0]    m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [jfds_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [jfds_pkg::CfgBits-1:0]        cfg_data_i
);

  logic               in_accept;
  logic               sum_valid;
  logic               sum_ready;
  jfds_pkg::summary_t sum;

  assign s_axis_tready = !sum_valid || sum_ready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  jfds_scanner u_scanner (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_accept_i  (in_accept),
    .frame_byte_i (s_axis_tdata),
    .last_byte_i  (s_axis_tlast),
    .sum_ready_i  (sum_ready),
    .sum_valid_o  (sum_valid),
    .sum_o        (sum)
  );

  jfds_classify u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .sum_valid_i (sum_valid),
    .sum_i       (sum),
    .sum_ready_o (sum_ready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

### sv/jfds_checker.sv
// ----------------------------------------------------------------------------
// jfds_checker
// Port-level checks on the result stream of the frame dimension scanner.
// ----------------------------------------------------------------------------
module jfds_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [jfds_pkg::OutDataBits-1:0] m_axis_tdata
);

  // A stalled result request keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Bad size and missing dimensions report all other fields as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[1:0] == jfds_pkg::STATUS_BAD_SIZE ||
                      m_axis_tdata[1:0] == jfds_pkg::STATUS_NO_DIMS)
    |-> m_axis_tdata[63:2] == '0)
    else $error("nonzero fields on a failed frame");

  // An oversized image carries no offsets and no fill flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] == jfds_pkg::STATUS_TOO_BIG
    |-> m_axis_tdata[63:34] == '0)
    else $error("offsets on an oversized image");

  // A good frame always has nonzero dimensions.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] == jfds_pkg::STATUS_OK
    |-> m_axis_tdata[17:2] != '0 && m_axis_tdata[33:18] != '0)
    else $error("good frame with a zero dimension");

  // With the output register empty, the input side is always ready for a byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output");

endmodule

bind jpeg_frame_dimension_scanner_top jfds_checker u_jfds_checker (.*);
